// File: hw/rtl/assert_macros.svh
// Assertion macros used by days_between_dates.
// Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: hw/rtl/dbd_pkg.sv
// Types, constants and calendar helper functions for the day-difference block.
// Used by dbd_ctrl, dbd_datapath and days_between_dates.
`default_nettype none
package dbd_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W = 5;
  localparam int unsigned ORD_W = 22;
  localparam int unsigned DIFF_W = 23;
  localparam int unsigned Q_W = 9;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  // floor(x/100) = (x * 5243) >> 19, exact for x below 43699
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_Q0   = 3'd1;
  localparam op_t OP_Q1   = 3'd2;
  localparam op_t OP_Q2   = 3'd3;
  localparam op_t OP_ACC  = 3'd4;
  localparam op_t OP_DIFF = 3'd5;

  localparam logic SEL_END   = 1'b0;
  localparam logic SEL_START = 1'b1;

  typedef struct packed {
    logic load;
    op_t  op;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd2: n = leap ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // days in the months before m, common year
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:  n = 9'd0;
      4'd2:  n = 9'd31;
      4'd3:  n = 9'd59;
      4'd4:  n = 9'd90;
      4'd5:  n = 9'd120;
      4'd6:  n = 9'd151;
      4'd7:  n = 9'd181;
      4'd8:  n = 9'd212;
      4'd9:  n = 9'd243;
      4'd10: n = 9'd273;
      4'd11: n = 9'd304;
      4'd12: n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [Q_W-1:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RECIP100);
    return p[RECIP_SHIFT +: Q_W];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/days_between_dates.sv
// Signed day count between two Gregorian dates (years 0-9999, 4/100/400 leap
// rule). A new pair of dates is accepted only while idle: after acceptance the
// two dates go one after the other through a four-step ordinal sequence that
// shares a single divide-by-100 reciprocal multiplier, then a difference step
// forms the difference into the output register. The result becomes valid
// in the same cycle that ready returns, and the result waits there
// until taken; if the previous result is still waiting when the next one is
// due, the block holds in the difference step and input stays blocked. An
// invalid date (year above 9999, bad month or day) gives date_error 1 and
// difference 0.
// Depends on dbd_pkg, dbd_ctrl, dbd_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module days_between_dates
  import dbd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [YEAR_W-1:0]   end_year_i,
  input  wire logic [MONTH_W-1:0]  end_month_i,
  input  wire logic [DAY_W-1:0]    end_day_i,
  input  wire logic [YEAR_W-1:0]   start_year_i,
  input  wire logic [MONTH_W-1:0]  start_month_i,
  input  wire logic [DAY_W-1:0]    start_day_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [DIFF_W-1:0] day_difference_o,
  output logic                     date_error_o
);

  cmd_t    cmd;
  status_t status;

  dbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dbd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .end_year_i       (end_year_i),
    .end_month_i      (end_month_i),
    .end_day_i        (end_day_i),
    .start_year_i     (start_year_i),
    .start_month_i    (start_month_i),
    .start_day_i      (start_day_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .day_difference_o (day_difference_o),
    .date_error_o     (date_error_o)
  );

  `ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, out_valid_o && date_error_o, day_difference_o == '0)
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_IMPLY(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))

endmodule
`default_nettype wire

// File: hw/rtl/dbd_ctrl.sv
// Sequencer for the day-difference block: walks both dates through the
// ordinal datapath and hands off the result. Depends on dbd_pkg.
`default_nettype none
module dbd_ctrl
  import dbd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_Q0   = 3'd1;
  localparam logic [2:0] ST_Q1   = 3'd2;
  localparam logic [2:0] ST_Q2   = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DIFF = 3'd5;

  logic [2:0] state_q, state_d;
  logic       sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    cmd_o.load = 1'b0;
    cmd_o.op = OP_NONE;
    cmd_o.sel = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          sel_d = SEL_END;
          state_d = ST_Q0;
        end
      end
      ST_Q0: begin
        cmd_o.op = OP_Q0;
        state_d = ST_Q1;
      end
      ST_Q1: begin
        cmd_o.op = OP_Q1;
        state_d = ST_Q2;
      end
      ST_Q2: begin
        cmd_o.op = OP_Q2;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        if (sel_q == SEL_END) begin
          sel_d = SEL_START;
          state_d = ST_Q0;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.op = OP_DIFF;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q <= SEL_END;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dbd_datapath.sv
// Datapath: captures the dates, computes day ordinals with one shared
// divide-by-100 unit, and holds the result register. Depends on dbd_pkg.
`default_nettype none
module dbd_datapath
  import dbd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire logic [YEAR_W-1:0]   end_year_i,
  input  wire logic [MONTH_W-1:0]  end_month_i,
  input  wire logic [DAY_W-1:0]    end_day_i,
  input  wire logic [YEAR_W-1:0]   start_year_i,
  input  wire logic [MONTH_W-1:0]  start_month_i,
  input  wire logic [DAY_W-1:0]    start_day_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [DIFF_W-1:0] day_difference_o,
  output logic                     date_error_o
);

  logic [YEAR_W-1:0]  ey_q, sy_q, y;
  logic [MONTH_W-1:0] em_q, sm_q, m;
  logic [DAY_W-1:0]   ed_q, sd_q, d;

  logic [Q_W-1:0]   t0_q, t1_q, t2_q, q_res;
  logic [14:0]      q_arg;
  logic             leap_q, valid_q, err_q;
  logic [ORD_W-1:0] y365_q, ord_end_q, ord_start_q, ord;
  logic [9:0]       msum_q;
  logic [14:0]      hund;
  logic             cent, leap_d, valid_d;
  logic [9:0]       msum_d;
  logic             out_valid_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic             derr_q;

  assign y = (cmd_i.sel == SEL_END) ? ey_q : sy_q;
  assign m = (cmd_i.sel == SEL_END) ? em_q : sm_q;
  assign d = (cmd_i.sel == SEL_END) ? ed_q : sd_q;

  // shared reciprocal divider: y, y+99, (y+399)/4
  always_comb begin
    case (cmd_i.op)
      OP_Q0:   q_arg = 15'(y);
      OP_Q1:   q_arg = 15'(y) + 15'd99;
      default: q_arg = 15'((15'(y) + 15'd399) >> 2);
    endcase
    q_res = div100(q_arg);
  end

  // leap: divisible by 4, and not a century unless the century is divisible by 4
  assign hund = 15'(t0_q) * 15'd100;
  assign cent = (hund == 15'(y));
  assign leap_d = (y[1:0] == 2'b00) && (!cent || (t0_q[1:0] == 2'b00));

  assign valid_d = (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) && (d != '0) &&
                   (d <= month_len(m, leap_q));
  assign msum_d = 10'(cum_days(m)) + 10'(leap_q && (m > 4'd2)) + 10'(d) - 10'd1;

  assign ord = y365_q + ORD_W'((15'(y) + 15'd3) >> 2) - ORD_W'(t1_q) + ORD_W'(t2_q)
             + ORD_W'(msum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ey_q <= end_year_i;
      em_q <= end_month_i;
      ed_q <= end_day_i;
      sy_q <= start_year_i;
      sm_q <= start_month_i;
      sd_q <= start_day_i;
    end
    case (cmd_i.op)
      OP_Q0: begin
        t0_q <= q_res;
        y365_q <= ORD_W'(y) * ORD_W'(365);
      end
      OP_Q1: begin
        t1_q <= q_res;
        leap_q <= leap_d;
      end
      OP_Q2: begin
        t2_q <= q_res;
        valid_q <= valid_d;
        msum_q <= msum_d;
      end
      OP_ACC: begin
        if (cmd_i.sel == SEL_END) begin
          ord_end_q <= ord;
        end else begin
          ord_start_q <= ord;
        end
      end
      OP_DIFF: begin
        derr_q <= err_q;
        diff_q <= err_q ? '0 : DIFF_W'(ord_end_q) - DIFF_W'(ord_start_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        err_q <= 1'b0;
      end else if (cmd_i.op == OP_ACC && !valid_q) begin
        err_q <= 1'b1;
      end
      if (cmd_i.op == OP_DIFF) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign day_difference_o = diff_q;
  assign date_error_o = derr_q;

endmodule
`default_nettype wire
